// ----- hw/rtl/lhcs_pkg.sv -----
// Shared types and constants for the L2CAP HID channel setup engine.
// Used by the front, queue and back modules and by the top level.
package lhcs_pkg;

  typedef enum logic [3:0] {
    KIND_CONN_RSP  = 4'd0,
    KIND_CFG_REQ   = 4'd1,
    KIND_CFG_RSP   = 4'd2,
    KIND_DISC_REQ  = 4'd3,
    KIND_DISC_RSP  = 4'd4,
    KIND_INFO_RSP  = 4'd5,
    KIND_CONN_REQ  = 4'd6,
    KIND_LINK_DISC = 4'd7,
    KIND_SET_PROTO = 4'd8,
    KIND_SDP_RSP   = 4'd9,
    KIND_CLAIM     = 4'd10,
    KIND_NONE      = 4'd11
  } kind_t;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_POLL   = 2'd1,
    OP_HOST_DISC = 2'd2,
    OP_IDLE   = 2'd3
  } op_t;

  localparam logic [7:0] SIG_CONN_REQ = 8'h02;
  localparam logic [7:0] SIG_CONN_RSP = 8'h03;
  localparam logic [7:0] SIG_CFG_REQ  = 8'h04;
  localparam logic [7:0] SIG_CFG_RSP  = 8'h05;
  localparam logic [7:0] SIG_DISC_REQ = 8'h06;
  localparam logic [7:0] SIG_DISC_RSP = 8'h07;
  localparam logic [7:0] SIG_INFO_REQ = 8'h0A;

  localparam logic [15:0] CID_SIGNAL = 16'h0001;
  localparam logic [15:0] CID_SDP    = 16'h0050;
  localparam logic [15:0] CID_CTRL   = 16'h0070;
  localparam logic [15:0] CID_INTR   = 16'h0071;
  localparam logic [15:0] PSM_SDP    = 16'h0001;
  localparam logic [15:0] PSM_CTRL   = 16'h0011;
  localparam logic [15:0] PSM_INTR   = 16'h0013;
  localparam logic [15:0] NO_LINK    = 16'hFFFF;

  localparam logic [1:0] CH_SDP  = 2'd0;
  localparam logic [1:0] CH_CTRL = 2'd1;
  localparam logic [1:0] CH_INTR = 2'd2;
  localparam logic [1:0] CH_NONE = 2'd3;

  localparam int F_CTRL_CONNECTED = 0;
  localparam int F_INTR_CONNECTED = 1;
  localparam int F_SDP_CONN_REQ   = 2;
  localparam int F_CTRL_CONN_REQ  = 3;
  localparam int F_INTR_CONN_REQ  = 4;
  localparam int F_SDP_CFG_OK     = 5;
  localparam int F_CTRL_CFG_OK    = 6;
  localparam int F_INTR_CFG_OK    = 7;
  localparam int F_SDP_DISC_REQ   = 8;
  localparam int F_SDP_DISC_RSP   = 9;
  localparam int F_CTRL_DISC_RSP  = 10;
  localparam int F_INTR_DISC_RSP  = 11;

  localparam logic [1:0] SP_WAIT     = 2'd0;
  localparam logic [1:0] SP_AWAIT_CFG = 2'd1;
  localparam logic [1:0] SP_AWAIT_DISC = 2'd2;

  localparam logic [3:0] CP_WAIT       = 4'd0;
  localparam logic [3:0] CP_CTRL_CFGD  = 4'd1;
  localparam logic [3:0] CP_INTR_SETUP = 4'd2;
  localparam logic [3:0] CP_CTRL_CONN  = 4'd3;
  localparam logic [3:0] CP_CTRL_CFG   = 4'd4;
  localparam logic [3:0] CP_INTR_CONN  = 4'd5;
  localparam logic [3:0] CP_INTR_CFG   = 4'd6;
  localparam logic [3:0] CP_DONE       = 4'd7;
  localparam logic [3:0] CP_INTR_DISC  = 4'd8;
  localparam logic [3:0] CP_CTRL_DISC  = 4'd9;

  localparam int MAX_RES = 8;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  ident;
    logic [15:0] local_cid;
    logic [15:0] remote_cid;
    logic [15:0] value;
    logic [7:0]  txn_low;
    logic [15:0] handle;
    logic [3:0]  claim;
  } result_t;

  // All results of one item, the index of the final one, and the link state.
  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [2:0]            last_idx;
    logic                  conn;
  } bundle_t;

  function automatic result_t mk(input kind_t k, input logic [7:0] id,
                                 input logic [15:0] lc, input logic [15:0] rc,
                                 input logic [15:0] v, input logic [7:0] tx,
                                 input logic [15:0] h, input logic [3:0] cl);
    result_t r;
    r.kind = k;
    r.ident = id;
    r.local_cid = lc;
    r.remote_cid = rc;
    r.value = v;
    r.txn_low = tx;
    r.handle = h;
    r.claim = cl;
    return r;
  endfunction

  function automatic logic [1:0] cid_index(input logic [15:0] cid);
    logic [1:0] r;
    r = CH_NONE;
    if (cid == CID_SDP) r = CH_SDP;
    else if (cid == CID_CTRL) r = CH_CTRL;
    else if (cid == CID_INTR) r = CH_INTR;
    return r;
  endfunction

  function automatic logic [15:0] local_of(input logic [1:0] ch);
    logic [15:0] r;
    case (ch)
      CH_SDP:  r = CID_SDP;
      CH_CTRL: r = CID_CTRL;
      default: r = CID_INTR;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/lhcs_front.sv -----
// Front part: holds the link and channel state, takes one item per cycle while
// accept is high and turns it into a bundle of signalling results. Depends on lhcs_pkg.
module lhcs_front import lhcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  op,
  input  logic [11:0] acl_handle,
  input  logic [11:0] link_handle,
  input  logic [15:0] channel_id,
  input  logic [7:0]  code,
  input  logic [7:0]  ident,
  input  logic [7:0]  txn_low,
  input  logic [15:0] word_a,
  input  logic [15:0] word_b,
  input  logic [15:0] word_c,
  input  logic [15:0] word_d,
  input  logic [3:0]  link_flags,
  input  logic        cfg_we,
  input  logic        cfg_mode,
  output bundle_t     bundle
);

  logic        protocol_mode;
  logic        hid_connected, active_link, sdp_open;
  logic [15:0] event_bits;
  logic [1:0]  sdp_phase;
  logic [3:0]  chan_phase;
  logic [15:0] link_id;
  logic [7:0]  sig_ident;
  logic [15:0] rcid0, rcid1, rcid2;

  logic        hc_next, al_next, so_next;
  logic [15:0] eb_next;
  logic [1:0]  sp_next;
  logic [3:0]  cp_next;
  logic [15:0] lid_next;
  logic [7:0]  sid_next;
  logic [15:0] r0_next, r1_next, r2_next;
  logic [3:0]  lf, lf_before;
  logic [1:0]  ch;
  logic [3:0]  n;
  logic [15:0] rc_sel;
  logic [15:0] proto_val;
  result_t [MAX_RES-1:0] res;

  assign proto_val = {12'h007, 3'b000, protocol_mode};

  always_comb begin
    hc_next = hid_connected;
    al_next = active_link;
    so_next = sdp_open;
    eb_next = event_bits;
    sp_next = sdp_phase;
    cp_next = chan_phase;
    lid_next = link_id;
    sid_next = sig_ident;
    r0_next = rcid0;
    r1_next = rcid1;
    r2_next = rcid2;
    lf = link_flags;
    lf_before = link_flags;
    ch = CH_NONE;
    rc_sel = '0;
    n = '0;
    res = '0;

    unique case (op_t'(op))
      OP_PACKET: begin
        if (!hc_next && code == SIG_CONN_REQ && word_a == PSM_SDP && !lf[3]) begin
          lf[3] = 1'b1;
          lid_next = {4'h0, link_handle};
          sp_next = SP_WAIT;
        end
        if (!lf[2] && lf[0] && !hc_next && !al_next && code == SIG_CONN_REQ &&
            word_a == PSM_CTRL) begin
          lf[0] = 1'b0;
          lf[2] = 1'b1;
          al_next = 1'b1;
          lid_next = {4'h0, link_handle};
          cp_next = CP_WAIT;
        end
        if (lf != lf_before) begin
          res[n[2:0]] = mk(KIND_CLAIM, '0, '0, '0, '0, '0, '0, lf);
          n = n + 4'd1;
        end

        if ({4'h0, acl_handle} == lid_next) begin
          if (channel_id == CID_SIGNAL) begin
            case (code)
              SIG_CONN_RSP: begin
                ch = cid_index(word_b);
                if (word_c == '0 && word_d == '0 && ch != CH_NONE) begin
                  sid_next = ident;
                  if (ch == CH_SDP) begin
                    r0_next = word_a;
                    sid_next = sid_next + 8'd1;
                    res[n[2:0]] = mk(KIND_CFG_REQ, sid_next, '0, r0_next, '0, '0,
                                     lid_next, '0);
                    n = n + 4'd1;
                  end else if (ch == CH_CTRL) begin
                    r1_next = word_a;
                    eb_next[F_CTRL_CONNECTED] = 1'b1;
                  end else begin
                    r2_next = word_a;
                    eb_next[F_INTR_CONNECTED] = 1'b1;
                  end
                end
              end
              SIG_CONN_REQ: begin
                if (word_a == PSM_SDP) begin
                  sid_next = ident;
                  r0_next = word_b;
                  eb_next[F_SDP_CONN_REQ] = 1'b1;
                end else if (word_a == PSM_CTRL) begin
                  sid_next = ident;
                  r1_next = word_b;
                  eb_next[F_CTRL_CONN_REQ] = 1'b1;
                end else if (word_a == PSM_INTR) begin
                  sid_next = ident;
                  r2_next = word_b;
                  eb_next[F_INTR_CONN_REQ] = 1'b1;
                end
              end
              SIG_CFG_RSP: begin
                ch = cid_index(word_a);
                if (word_c == '0 && ch != CH_NONE) begin
                  sid_next = ident;
                  if (ch == CH_SDP) eb_next[F_SDP_CFG_OK] = 1'b1;
                  else if (ch == CH_CTRL) eb_next[F_CTRL_CFG_OK] = 1'b1;
                  else eb_next[F_INTR_CFG_OK] = 1'b1;
                end
              end
              SIG_CFG_REQ: begin
                ch = cid_index(word_a);
                rc_sel = (ch == CH_SDP) ? r0_next : (ch == CH_CTRL) ? r1_next : r2_next;
                if (ch != CH_NONE) begin
                  res[n[2:0]] = mk(KIND_CFG_RSP, ident, '0, rc_sel, '0, '0, lid_next, '0);
                  n = n + 4'd1;
                end
              end
              SIG_DISC_REQ: begin
                ch = cid_index(word_a);
                rc_sel = (ch == CH_CTRL) ? r1_next : r2_next;
                if (ch == CH_SDP) begin
                  sid_next = ident;
                  eb_next[F_SDP_DISC_REQ] = 1'b1;
                end else if (ch != CH_NONE) begin
                  sid_next = ident;
                  res[n[2:0]] = mk(KIND_DISC_RSP, sid_next, local_of(ch), rc_sel, '0, '0,
                                   lid_next, '0);
                  n = n + 4'd1;
                  hc_next = 1'b0;
                  al_next = 1'b0;
                  so_next = 1'b0;
                  eb_next = '0;
                  sp_next = SP_WAIT;
                  cp_next = CP_WAIT;
                end
              end
              SIG_DISC_RSP: begin
                // The first channel whose remote CID matches takes the flag.
                if (r0_next == word_a) begin
                  sid_next = ident;
                  eb_next[F_SDP_DISC_RSP] = 1'b1;
                end else if (r1_next == word_a) begin
                  sid_next = ident;
                  eb_next[F_CTRL_DISC_RSP] = 1'b1;
                end else if (r2_next == word_a) begin
                  sid_next = ident;
                  eb_next[F_INTR_DISC_RSP] = 1'b1;
                end
              end
              SIG_INFO_REQ: begin
                sid_next = ident;
                res[n[2:0]] = mk(KIND_INFO_RSP, sid_next, '0, '0, word_a, '0, lid_next, '0);
                n = n + 4'd1;
              end
              default: ;
            endcase
          end else if (channel_id == CID_SDP) begin
            if (code == SIG_CONN_REQ || code == SIG_CFG_REQ || code == SIG_DISC_REQ) begin
              res[n[2:0]] = mk(KIND_SDP_RSP, ident, '0, r0_next,
                               {8'h00, code + 8'd1}, txn_low, lid_next, '0);
              n = n + 4'd1;
            end
          end

          // SDP channel task.
          if (sp_next == SP_WAIT) begin
            if (eb_next[F_SDP_CONN_REQ]) begin
              eb_next[F_SDP_CONN_REQ] = 1'b0;
              res[n[2:0]] = mk(KIND_CONN_RSP, sid_next, CID_SDP, r0_next, 16'd1, '0,
                               lid_next, '0);
              n = n + 4'd1;
              res[n[2:0]] = mk(KIND_CONN_RSP, sid_next, CID_SDP, r0_next, 16'd0, '0,
                               lid_next, '0);
              n = n + 4'd1;
              sid_next = sid_next + 8'd1;
              res[n[2:0]] = mk(KIND_CFG_REQ, sid_next, '0, r0_next, '0, '0, lid_next, '0);
              n = n + 4'd1;
              sp_next = SP_AWAIT_CFG;
            end else if (eb_next[F_SDP_DISC_REQ]) begin
              eb_next[F_SDP_DISC_REQ] = 1'b0;
              so_next = 1'b0;
              res[n[2:0]] = mk(KIND_DISC_RSP, sid_next, CID_SDP, r0_next, '0, '0,
                               lid_next, '0);
              n = n + 4'd1;
            end
          end else if (sp_next == SP_AWAIT_CFG) begin
            if (eb_next[F_SDP_CFG_OK]) begin
              eb_next[F_SDP_CFG_OK] = 1'b0;
              so_next = 1'b1;
              sp_next = SP_WAIT;
            end
          end else if (sp_next == SP_AWAIT_DISC) begin
            if (eb_next[F_SDP_DISC_RSP]) begin
              res[n[2:0]] = mk(KIND_LINK_DISC, '0, '0, '0, '0, '0, lid_next, '0);
              n = n + 4'd1;
              lid_next = NO_LINK;
              hc_next = 1'b0;
              al_next = 1'b0;
              so_next = 1'b0;
              eb_next = '0;
              sp_next = SP_WAIT;
              cp_next = CP_WAIT;
            end
          end

          // HID channel task.
          case (cp_next)
            CP_CTRL_CFGD: begin
              if (eb_next[F_CTRL_CFG_OK]) begin
                res[n[2:0]] = mk(KIND_SET_PROTO, '0, '0, r1_next, proto_val, '0,
                                 lid_next, '0);
                n = n + 4'd1;
                cp_next = CP_INTR_SETUP;
              end
            end
            CP_INTR_SETUP: begin
              if (eb_next[F_INTR_CONN_REQ]) begin
                res[n[2:0]] = mk(KIND_CONN_RSP, sid_next, CID_INTR, r2_next, 16'd1, '0,
                                 lid_next, '0);
                n = n + 4'd1;
                res[n[2:0]] = mk(KIND_CONN_RSP, sid_next, CID_INTR, r2_next, 16'd0, '0,
                                 lid_next, '0);
                n = n + 4'd1;
                sid_next = sid_next + 8'd1;
                res[n[2:0]] = mk(KIND_CFG_REQ, sid_next, '0, r2_next, '0, '0, lid_next, '0);
                n = n + 4'd1;
                cp_next = CP_INTR_CFG;
              end
            end
            CP_CTRL_CONN: begin
              if (eb_next[F_CTRL_CONNECTED]) begin
                sid_next = sid_next + 8'd1;
                res[n[2:0]] = mk(KIND_CFG_REQ, sid_next, '0, r1_next, '0, '0, lid_next, '0);
                n = n + 4'd1;
                cp_next = CP_CTRL_CFG;
              end
            end
            CP_CTRL_CFG: begin
              if (eb_next[F_CTRL_CFG_OK]) begin
                res[n[2:0]] = mk(KIND_SET_PROTO, '0, '0, r1_next, proto_val, '0,
                                 lid_next, '0);
                n = n + 4'd1;
                sid_next = sid_next + 8'd1;
                res[n[2:0]] = mk(KIND_CONN_REQ, sid_next, CID_INTR, '0, PSM_INTR, '0,
                                 lid_next, '0);
                n = n + 4'd1;
                cp_next = CP_INTR_CONN;
              end
            end
            CP_INTR_CONN: begin
              if (eb_next[F_INTR_CONNECTED]) begin
                sid_next = sid_next + 8'd1;
                res[n[2:0]] = mk(KIND_CFG_REQ, sid_next, '0, r2_next, '0, '0, lid_next, '0);
                n = n + 4'd1;
                cp_next = CP_INTR_CFG;
              end
            end
            CP_INTR_CFG: begin
              if (eb_next[F_INTR_CFG_OK]) begin
                if (lf[1]) begin
                  lf[1] = 1'b0;
                  res[n[2:0]] = mk(KIND_CLAIM, '0, '0, '0, '0, '0, '0, lf);
                  n = n + 4'd1;
                end
                hc_next = 1'b1;
                cp_next = CP_DONE;
              end
            end
            CP_INTR_DISC: begin
              if (eb_next[F_INTR_DISC_RSP]) begin
                sid_next = sid_next + 8'd1;
                res[n[2:0]] = mk(KIND_DISC_REQ, sid_next, CID_CTRL, r1_next, '0, '0,
                                 lid_next, '0);
                n = n + 4'd1;
                cp_next = CP_CTRL_DISC;
              end
            end
            CP_CTRL_DISC: begin
              if (eb_next[F_CTRL_DISC_RSP]) begin
                res[n[2:0]] = mk(KIND_LINK_DISC, '0, '0, '0, '0, '0, lid_next, '0);
                n = n + 4'd1;
                lid_next = NO_LINK;
                eb_next = '0;
                cp_next = CP_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      OP_POLL: begin
        if (chan_phase == CP_WAIT) begin
          if (lf[1] && !lf[2] && !hid_connected && !active_link) begin
            lf[2] = 1'b1;
            res[n[2:0]] = mk(KIND_CLAIM, '0, '0, '0, '0, '0, '0, lf);
            n = n + 4'd1;
            al_next = 1'b1;
            lid_next = {4'h0, link_handle};
            eb_next = '0;
            sid_next = '0;
            res[n[2:0]] = mk(KIND_CONN_REQ, '0, CID_CTRL, '0, PSM_CTRL, '0, lid_next, '0);
            n = n + 4'd1;
            cp_next = CP_CTRL_CONN;
          end else if (event_bits[F_CTRL_CONN_REQ]) begin
            res[n[2:0]] = mk(KIND_CONN_RSP, sid_next, CID_CTRL, rcid1, 16'd1, '0,
                             link_id, '0);
            n = n + 4'd1;
            res[n[2:0]] = mk(KIND_CONN_RSP, sid_next, CID_CTRL, rcid1, 16'd0, '0,
                             link_id, '0);
            n = n + 4'd1;
            sid_next = sid_next + 8'd1;
            res[n[2:0]] = mk(KIND_CFG_REQ, sid_next, '0, rcid1, '0, '0, link_id, '0);
            n = n + 4'd1;
            cp_next = CP_CTRL_CFGD;
          end
        end
      end
      OP_HOST_DISC: begin
        if (sdp_open) begin
          sid_next = sid_next + 8'd1;
          res[n[2:0]] = mk(KIND_DISC_REQ, sid_next, CID_SDP, rcid0, '0, '0, link_id, '0);
          n = n + 4'd1;
        end
        sid_next = sid_next + 8'd1;
        res[n[2:0]] = mk(KIND_DISC_REQ, sid_next, CID_INTR, rcid2, '0, '0, link_id, '0);
        n = n + 4'd1;
        hc_next = 1'b0;
        al_next = 1'b0;
        so_next = 1'b0;
        eb_next = '0;
        sp_next = SP_AWAIT_DISC;
        cp_next = CP_INTR_DISC;
      end
      OP_IDLE: ;
    endcase

    if (n == 4'd0) begin
      res[0] = mk(KIND_NONE, '0, '0, '0, '0, '0, '0, '0);
      n = 4'd1;
    end
  end

  assign bundle.res = res;
  assign bundle.last_idx = 3'(n - 4'd1);
  assign bundle.conn = hc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode <= 1'b0;
      hid_connected <= 1'b0;
      active_link <= 1'b0;
      sdp_open <= 1'b0;
      event_bits <= '0;
      sdp_phase <= SP_WAIT;
      chan_phase <= CP_WAIT;
      link_id <= NO_LINK;
      sig_ident <= '0;
      rcid0 <= '0;
      rcid1 <= '0;
      rcid2 <= '0;
    end else begin
      if (cfg_we) protocol_mode <= cfg_mode;
      if (accept) begin
        hid_connected <= hc_next;
        active_link <= al_next;
        sdp_open <= so_next;
        event_bits <= eb_next;
        sdp_phase <= sp_next;
        chan_phase <= cp_next;
        link_id <= lid_next;
        sig_ident <= sid_next;
        rcid0 <= r0_next;
        rcid1 <= r1_next;
        rcid2 <= r2_next;
      end
    end
  end

endmodule

// ----- hw/rtl/lhcs_fifo.sv -----
// Two-entry queue of result bundles between the front and the back part.
// Depends on lhcs_pkg.
module lhcs_fifo import lhcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_i,
  input  bundle_t din,
  input  logic    pop_i,
  output bundle_t dout,
  output logic    full_o,
  output logic    empty_o
);

  bundle_t    mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full_o = (cnt == 2'd2);
  assign empty_o = (cnt == 2'd0);
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (push_i) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push_i) wp <= ~wp;
      if (pop_i) rp <= ~rp;
      cnt <= cnt + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop_i |-> cnt != 2'd0)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push_i && !pop_i |-> cnt != 2'd2)
    else $error("push into full queue");
`endif

endmodule

// ----- hw/rtl/lhcs_back.sv -----
// Back part: walks through the results of the bundle at the queue head and
// places them one per cycle in the output register while it is empty or popped. Depends on lhcs_pkg.
module lhcs_back import lhcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  bundle_t head,
  input  logic    q_empty,
  output logic    q_pop,
  input  logic    pop,
  output logic    empty,
  output result_t res_o,
  output logic    conn_o,
  output logic    last_o
);

  logic       ovalid;
  logic [2:0] idx;
  logic       load;
  logic       at_last;

  assign empty = !ovalid;
  assign load = !q_empty && (!ovalid || pop);
  assign at_last = (idx == head.last_idx);
  assign q_pop = load && at_last;

  always_ff @(posedge clk) begin
    if (load) begin
      res_o <= head.res[idx];
      conn_o <= head.conn;
      last_o <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) ovalid <= 1'b1;
      else if (pop) ovalid <= 1'b0;
      if (load) idx <= at_last ? 3'd0 : idx + 3'd1;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !pop |=> ovalid && $stable(res_o) && $stable(last_o))
    else $error("waiting result changed");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx <= head.last_idx)
    else $error("result index past end of bundle");
  a_idx_reset: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> idx == 3'd0)
    else $error("index not cleared after bundle");
`endif

endmodule

// ----- hw/rtl/l2cap_hid_channel_setup.sv -----
// L2CAP HID channel setup engine, top level.
// Depends on lhcs_pkg, lhcs_front, lhcs_fifo and lhcs_back.
//
// Each item (received packet header, poll tick or host disconnect) is taken by
// the front part, which updates the link state and builds all of the item's
// commands at once; a two-entry queue then holds up to two such bundles. The
// back part delivers one result per cycle while pop is high, each item giving
// 1 to 8 results, and a new item is accepted every cycle as long as the queue
// has room. The last result of an item carries last = 1. protocol_mode is
// written through the cfg channel, which is always ready.
module l2cap_hid_channel_setup import lhcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [11:0] acl_handle,
  input  logic [11:0] link_handle,
  input  logic [15:0] channel_id,
  input  logic [7:0]  code,
  input  logic [7:0]  ident,
  input  logic [7:0]  txn_low,
  input  logic [15:0] word_a,
  input  logic [15:0] word_b,
  input  logic [15:0] word_c,
  input  logic [15:0] word_d,
  input  logic [3:0]  link_flags,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        protocol_mode,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  kind,
  output logic [7:0]  out_ident,
  output logic [15:0] out_local_cid,
  output logic [15:0] out_remote_cid,
  output logic [15:0] out_value,
  output logic [7:0]  out_txn_low,
  output logic [15:0] out_handle,
  output logic [3:0]  claim_bits,
  output logic        is_connected,
  output logic        last
);

  bundle_t front_b, head_b;
  logic    accept, q_empty, q_pop;
  result_t res;

  assign cfg_ready = 1'b1;
  assign accept = push && !full;

  lhcs_front u_front (
    .clk, .rst, .accept, .op, .acl_handle, .link_handle, .channel_id, .code,
    .ident, .txn_low, .word_a, .word_b, .word_c, .word_d, .link_flags,
    .cfg_we(cfg_valid && cfg_ready), .cfg_mode(protocol_mode), .bundle(front_b)
  );

  lhcs_fifo u_fifo (
    .clk, .rst, .push_i(accept), .din(front_b), .pop_i(q_pop), .dout(head_b),
    .full_o(full), .empty_o(q_empty)
  );

  lhcs_back u_back (
    .clk, .rst, .head(head_b), .q_empty, .q_pop, .pop, .empty, .res_o(res),
    .conn_o(is_connected), .last_o(last)
  );

  assign kind = res.kind;
  assign out_ident = res.ident;
  assign out_local_cid = res.local_cid;
  assign out_remote_cid = res.remote_cid;
  assign out_value = res.value;
  assign out_txn_low = res.txn_low;
  assign out_handle = res.handle;
  assign claim_bits = res.claim;

endmodule

// ----- sim/tb_l2cap_hid_channel_setup.sv -----
// Testbench for the L2CAP HID channel setup engine: directed link setups and
// teardowns, then random sequences and noise, checked against a predictor.
// Depends on lhcs_pkg and l2cap_hid_channel_setup.
`timescale 1ns / 1ps

module tb_l2cap_hid_channel_setup;
  import lhcs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 420;

  typedef struct {
    op_t         op;
    logic [11:0] acl;
    logic [11:0] lnk;
    logic [15:0] chan;
    logic [7:0]  code;
    logic [7:0]  id;
    logic [7:0]  txn;
    logic [15:0] wa, wb, wc, wd;
    logic [3:0]  flags;
  } item_t;

  typedef struct {
    result_t r;
    logic    conn;
    logic    fin;
  } cmd_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] op = OP_IDLE;
  logic [11:0] acl_handle = '0, link_handle = '0;
  logic [15:0] channel_id = '0;
  logic [7:0] code = '0, ident = '0, txn_low = '0;
  logic [15:0] word_a = '0, word_b = '0, word_c = '0, word_d = '0;
  logic [3:0] link_flags = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic protocol_mode = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [3:0] kind;
  logic [7:0] out_ident, out_txn_low;
  logic [15:0] out_local_cid, out_remote_cid, out_value, out_handle;
  logic [3:0] claim_bits;
  logic is_connected, last;

  l2cap_hid_channel_setup dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .acl_handle(acl_handle), .link_handle(link_handle), .channel_id(channel_id),
    .code(code), .ident(ident), .txn_low(txn_low), .word_a(word_a),
    .word_b(word_b), .word_c(word_c), .word_d(word_d), .link_flags(link_flags),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .protocol_mode(protocol_mode),
    .empty(empty), .pop(pop), .kind(kind), .out_ident(out_ident),
    .out_local_cid(out_local_cid), .out_remote_cid(out_remote_cid),
    .out_value(out_value), .out_txn_low(out_txn_low), .out_handle(out_handle),
    .claim_bits(claim_bits), .is_connected(is_connected), .last(last)
  );

  always #2 clk = ~clk;

  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  cmd_exp_t cmd_q[$];
  logic [11:0] cur_h;

  // Predicted link state.
  logic        p_mode, p_hid, p_active, p_sdp_open;
  logic [15:0] p_ev, p_link;
  logic [1:0]  p_sp;
  logic [3:0]  p_cp, p_lf;
  logic [7:0]  p_sid;
  logic [15:0] p_rcid[3];
  result_t     p_buf[MAX_RES];
  int          p_n;

  function automatic logic [15:0] our_cid(int ch);
    return (ch == 0) ? CID_SDP : (ch == 1) ? CID_CTRL : CID_INTR;
  endfunction

  function automatic int chan_of(logic [15:0] cid);
    return (cid == CID_SDP) ? 0 : (cid == CID_CTRL) ? 1 : (cid == CID_INTR) ? 2 : 3;
  endfunction

  function automatic void add_cmd(kind_t k, logic [7:0] id, logic [15:0] lc,
                                  logic [15:0] rc, logic [15:0] v, logic [7:0] tx,
                                  logic [15:0] h, logic [3:0] cl);
    result_t r;
    if (p_n >= MAX_RES) return;
    r.kind = k;
    r.ident = id;
    r.local_cid = lc;
    r.remote_cid = rc;
    r.value = v;
    r.txn_low = tx;
    r.handle = h;
    r.claim = cl;
    p_buf[p_n] = r;
    p_n++;
  endfunction

  function automatic void sig_cmd(kind_t k, logic [7:0] id, logic [15:0] lc,
                                  logic [15:0] rc, logic [15:0] v);
    add_cmd(k, id, lc, rc, v, 8'd0, p_link, 4'd0);
  endfunction

  function automatic void claim_update(logic [3:0] prev);
    if (p_lf != prev) add_cmd(KIND_CLAIM, 0, 0, 0, 0, 0, 0, p_lf);
  endfunction

  function automatic void drop_link_state();
    p_hid = 0;
    p_active = 0;
    p_sdp_open = 0;
    p_ev = '0;
    p_sp = SP_WAIT;
    p_cp = CP_WAIT;
  endfunction

  // Pending then success connection response, then our config request.
  function automatic void accept_chan(int ch);
    sig_cmd(KIND_CONN_RSP, p_sid, our_cid(ch), p_rcid[ch], 16'd1);
    sig_cmd(KIND_CONN_RSP, p_sid, our_cid(ch), p_rcid[ch], 16'd0);
    p_sid = p_sid + 8'd1;
    sig_cmd(KIND_CFG_REQ, p_sid, 0, p_rcid[ch], 0);
  endfunction

  function automatic void sdp_advance();
    if (p_sp == SP_WAIT) begin
      if (p_ev[F_SDP_CONN_REQ]) begin
        p_ev[F_SDP_CONN_REQ] = 0;
        accept_chan(0);
        p_sp = SP_AWAIT_CFG;
      end else if (p_ev[F_SDP_DISC_REQ]) begin
        p_ev[F_SDP_DISC_REQ] = 0;
        p_sdp_open = 0;
        sig_cmd(KIND_DISC_RSP, p_sid, CID_SDP, p_rcid[0], 0);
      end
    end else if (p_sp == SP_AWAIT_CFG) begin
      if (p_ev[F_SDP_CFG_OK]) begin
        p_ev[F_SDP_CFG_OK] = 0;
        p_sdp_open = 1;
        p_sp = SP_WAIT;
      end
    end else if (p_sp == SP_AWAIT_DISC) begin
      if (p_ev[F_SDP_DISC_RSP]) begin
        sig_cmd(KIND_LINK_DISC, 0, 0, 0, 0);
        p_link = NO_LINK;
        drop_link_state();
      end
    end
  endfunction

  function automatic void hid_advance();
    logic [3:0] prev;
    case (p_cp)
      CP_CTRL_CFGD: if (p_ev[F_CTRL_CFG_OK]) begin
        sig_cmd(KIND_SET_PROTO, 0, 0, p_rcid[1], {15'h0038, p_mode});
        p_cp = CP_INTR_SETUP;
      end
      CP_INTR_SETUP: if (p_ev[F_INTR_CONN_REQ]) begin
        accept_chan(2);
        p_cp = CP_INTR_CFG;
      end
      CP_CTRL_CONN: if (p_ev[F_CTRL_CONNECTED]) begin
        p_sid = p_sid + 8'd1;
        sig_cmd(KIND_CFG_REQ, p_sid, 0, p_rcid[1], 0);
        p_cp = CP_CTRL_CFG;
      end
      CP_CTRL_CFG: if (p_ev[F_CTRL_CFG_OK]) begin
        sig_cmd(KIND_SET_PROTO, 0, 0, p_rcid[1], {15'h0038, p_mode});
        p_sid = p_sid + 8'd1;
        sig_cmd(KIND_CONN_REQ, p_sid, CID_INTR, 0, PSM_INTR);
        p_cp = CP_INTR_CONN;
      end
      CP_INTR_CONN: if (p_ev[F_INTR_CONNECTED]) begin
        p_sid = p_sid + 8'd1;
        sig_cmd(KIND_CFG_REQ, p_sid, 0, p_rcid[2], 0);
        p_cp = CP_INTR_CFG;
      end
      CP_INTR_CFG: if (p_ev[F_INTR_CFG_OK]) begin
        prev = p_lf;
        p_lf[1] = 0;
        claim_update(prev);
        p_hid = 1;
        p_cp = CP_DONE;
      end
      CP_INTR_DISC: if (p_ev[F_INTR_DISC_RSP]) begin
        p_sid = p_sid + 8'd1;
        sig_cmd(KIND_DISC_REQ, p_sid, CID_CTRL, p_rcid[1], 0);
        p_cp = CP_CTRL_DISC;
      end
      CP_CTRL_DISC: if (p_ev[F_CTRL_DISC_RSP]) begin
        sig_cmd(KIND_LINK_DISC, 0, 0, 0, 0);
        p_link = NO_LINK;
        p_ev = '0;
        p_cp = CP_WAIT;
      end
      default: ;
    endcase
  endfunction

  function automatic void signalling(item_t it);
    int ch;
    case (it.code)
      SIG_CONN_RSP: begin
        ch = chan_of(it.wb);
        if (it.wc == 0 && it.wd == 0 && ch < 3) begin
          p_sid = it.id;
          p_rcid[ch] = it.wa;
          if (ch == 0) begin
            p_sid = p_sid + 8'd1;
            sig_cmd(KIND_CFG_REQ, p_sid, 0, p_rcid[0], 0);
          end else if (ch == 1) p_ev[F_CTRL_CONNECTED] = 1;
          else p_ev[F_INTR_CONNECTED] = 1;
        end
      end
      SIG_CONN_REQ: begin
        ch = (it.wa == PSM_SDP) ? 0 : (it.wa == PSM_CTRL) ? 1 : (it.wa == PSM_INTR) ? 2 : 3;
        if (ch < 3) begin
          p_sid = it.id;
          p_rcid[ch] = it.wb;
          p_ev[(ch == 0) ? F_SDP_CONN_REQ : (ch == 1) ? F_CTRL_CONN_REQ : F_INTR_CONN_REQ] = 1;
        end
      end
      SIG_CFG_RSP: begin
        ch = chan_of(it.wa);
        if (it.wc == 0 && ch < 3) begin
          p_sid = it.id;
          p_ev[(ch == 0) ? F_SDP_CFG_OK : (ch == 1) ? F_CTRL_CFG_OK : F_INTR_CFG_OK] = 1;
        end
      end
      SIG_CFG_REQ: begin
        ch = chan_of(it.wa);
        if (ch < 3) sig_cmd(KIND_CFG_RSP, it.id, 0, p_rcid[ch], 0);
      end
      SIG_DISC_REQ: begin
        ch = chan_of(it.wa);
        if (ch == 0) begin
          p_sid = it.id;
          p_ev[F_SDP_DISC_REQ] = 1;
        end else if (ch < 3) begin
          p_sid = it.id;
          sig_cmd(KIND_DISC_RSP, p_sid, our_cid(ch), p_rcid[ch], 0);
          drop_link_state();
        end
      end
      SIG_DISC_RSP: begin
        for (int i = 0; i < 3; i++) begin
          if (p_rcid[i] == it.wa) begin
            p_sid = it.id;
            p_ev[(i == 0) ? F_SDP_DISC_RSP : (i == 1) ? F_CTRL_DISC_RSP : F_INTR_DISC_RSP] = 1;
            break;
          end
        end
      end
      SIG_INFO_REQ: begin
        p_sid = it.id;
        sig_cmd(KIND_INFO_RSP, p_sid, 0, 0, it.wa);
      end
      default: ;
    endcase
  endfunction

  function automatic void on_packet(item_t it);
    logic [3:0] prev;
    prev = p_lf;
    if (!p_hid && it.code == SIG_CONN_REQ && it.wa == PSM_SDP && !p_lf[3]) begin
      p_lf[3] = 1;
      p_link = {4'd0, it.lnk};
      p_sp = SP_WAIT;
    end
    if (!p_lf[2] && p_lf[0] && !p_hid && !p_active && it.code == SIG_CONN_REQ &&
        it.wa == PSM_CTRL) begin
      p_lf[0] = 0;
      p_lf[2] = 1;
      p_active = 1;
      p_link = {4'd0, it.lnk};
      p_cp = CP_WAIT;
    end
    claim_update(prev);
    if ({4'd0, it.acl} != p_link) return;
    if (it.chan == CID_SIGNAL) signalling(it);
    else if (it.chan == CID_SDP && (it.code == SIG_CONN_REQ || it.code == SIG_CFG_REQ ||
                                    it.code == SIG_DISC_REQ))
      add_cmd(KIND_SDP_RSP, it.id, 0, p_rcid[0], {8'd0, it.code} + 16'd1, it.txn, p_link, 0);
    sdp_advance();
    hid_advance();
  endfunction

  function automatic void on_poll(item_t it);
    logic [3:0] prev;
    prev = p_lf;
    if (p_cp != CP_WAIT) return;
    if (p_lf[1] && !p_lf[2] && !p_hid && !p_active) begin
      p_lf[2] = 1;
      claim_update(prev);
      p_active = 1;
      p_link = {4'd0, it.lnk};
      p_ev = '0;
      p_sid = 0;
      sig_cmd(KIND_CONN_REQ, p_sid, CID_CTRL, 0, PSM_CTRL);
      p_cp = CP_CTRL_CONN;
    end else if (p_ev[F_CTRL_CONN_REQ]) begin
      accept_chan(1);
      p_cp = CP_CTRL_CFGD;
    end
  endfunction

  function automatic void on_host_disc();
    if (p_sdp_open) begin
      p_sid = p_sid + 8'd1;
      sig_cmd(KIND_DISC_REQ, p_sid, CID_SDP, p_rcid[0], 0);
    end
    p_sid = p_sid + 8'd1;
    sig_cmd(KIND_DISC_REQ, p_sid, CID_INTR, p_rcid[2], 0);
    drop_link_state();
    p_sp = SP_AWAIT_DISC;
    p_cp = CP_INTR_DISC;
  endfunction

  // Runs one accepted item through the predictor and queues its commands.
  function automatic void predict_commands(item_t it);
    cmd_exp_t e;
    p_n = 0;
    p_lf = it.flags;
    case (it.op)
      OP_PACKET:    on_packet(it);
      OP_POLL:      on_poll(it);
      OP_HOST_DISC: on_host_disc();
      default: ;
    endcase
    if (p_n == 0) add_cmd(KIND_NONE, 0, 0, 0, 0, 0, 0, 0);
    for (int k = 0; k < p_n; k++) begin
      e.r = p_buf[k];
      e.conn = p_hid;
      e.fin = (k == p_n - 1);
      cmd_q.push_back(e);
    end
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Result side: checks every popped result and stalls in random bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    cmd_exp_t e;
    if (!rst && pop && !empty) begin
      if (cmd_q.size() == 0) report("unexpected result, kind", 16'(kind), 16'(KIND_NONE));
      else begin
        e = cmd_q.pop_front();
        if (kind != e.r.kind) report("kind", 16'(kind), 16'(e.r.kind));
        if (out_ident != e.r.ident) report("out_ident", 16'(out_ident), 16'(e.r.ident));
        if (out_local_cid != e.r.local_cid)
          report("out_local_cid", out_local_cid, e.r.local_cid);
        if (out_remote_cid != e.r.remote_cid)
          report("out_remote_cid", out_remote_cid, e.r.remote_cid);
        if (out_value != e.r.value) report("out_value", out_value, e.r.value);
        if (out_txn_low != e.r.txn_low)
          report("out_txn_low", 16'(out_txn_low), 16'(e.r.txn_low));
        if (out_handle != e.r.handle) report("out_handle", out_handle, e.r.handle);
        if (claim_bits != e.r.claim) report("claim_bits", 16'(claim_bits), 16'(e.r.claim));
        if (is_connected != e.conn)
          report("is_connected", 16'(is_connected), 16'(e.conn));
        if (last != e.fin) report("last", 16'(last), 16'(e.fin));
      end
    end
    if (rst) pop <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 17) - 1;
      pop <= 1'b0;
    end else pop <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sends one item, after a random gap unless quiet; push stays high so back-to-back items need no gap.
  task automatic send_item(item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    push <= 1'b1;
    op <= it.op;
    acl_handle <= it.acl;
    link_handle <= it.lnk;
    channel_id <= it.chan;
    code <= it.code;
    ident <= it.id;
    txn_low <= it.txn;
    word_a <= it.wa;
    word_b <= it.wb;
    word_c <= it.wc;
    word_d <= it.wd;
    link_flags <= it.flags;
    do @(posedge clk); while (full);
    predict_commands(it);
  endtask

  function automatic item_t noise_item();
    item_t it;
    it.op = op_t'($urandom_range(0, 3));
    it.acl = 12'($urandom);
    it.lnk = 12'($urandom);
    it.chan = 16'($urandom);
    it.code = 8'($urandom);
    it.id = 8'($urandom);
    it.txn = 8'($urandom);
    it.wa = 16'($urandom);
    it.wb = 16'($urandom);
    it.wc = 16'($urandom);
    it.wd = 16'($urandom);
    it.flags = 4'($urandom);
    // Bias toward the current link and meaningful codes so noise reaches the engine.
    if ($urandom_range(0, 1)) begin
      it.acl = cur_h;
      it.lnk = cur_h;
      it.chan = $urandom_range(0, 1) ? CID_SIGNAL : CID_SDP;
      it.code = 8'($urandom_range(2, 10));
      it.wc = $urandom_range(0, 3) ? 16'd0 : it.wc;
      it.wd = $urandom_range(0, 3) ? 16'd0 : it.wd;
    end
    return it;
  endfunction

  function automatic item_t sig_item(logic [15:0] chan, logic [7:0] c, logic [15:0] wa,
                                     logic [15:0] wb, logic [3:0] flags);
    item_t it;
    it = noise_item();
    it.op = OP_PACKET;
    it.acl = cur_h;
    it.lnk = cur_h;
    it.chan = chan;
    it.code = c;
    it.wa = wa;
    it.wb = wb;
    it.wc = 0;
    it.wd = 0;
    it.flags = flags;
    return it;
  endfunction

  function automatic item_t ctl_item(op_t o, logic [3:0] flags);
    item_t it;
    it = noise_item();
    it.op = o;
    it.lnk = cur_h;
    it.flags = flags;
    return it;
  endfunction

  // Host disconnect, then the peer confirms every channel so the HID channel task returns to wait.
  task automatic teardown();
    send_item(ctl_item(OP_HOST_DISC, 4'($urandom)));
    if (p_link != NO_LINK) begin
      cur_h = p_link[11:0];
      send_item(sig_item(CID_SIGNAL, SIG_DISC_RSP, p_rcid[2], 0, 4'($urandom)));
      send_item(sig_item(CID_SIGNAL, SIG_DISC_RSP, p_rcid[1], 0, 4'($urandom)));
      send_item(sig_item(CID_SIGNAL, SIG_DISC_RSP, p_rcid[0], 0, 4'($urandom)));
    end
  endtask

  task automatic incoming_setup();
    logic [15:0] rc;
    rc = 16'($urandom_range(16'h0040, 16'hFF00));
    cur_h = 12'($urandom);
    send_item(sig_item(CID_SIGNAL, SIG_CONN_REQ, PSM_SDP, rc, 4'b0001 | 4'($urandom & 2)));
    send_item(sig_item(CID_SIGNAL, SIG_CFG_RSP, CID_SDP, 0, 4'($urandom)));
    send_item(sig_item(CID_SIGNAL, SIG_CFG_REQ, CID_SDP, 0, 4'($urandom)));
    send_item(sig_item(CID_SIGNAL, SIG_CONN_REQ, PSM_CTRL, rc + 16'd1, 4'b0001));
    send_item(ctl_item(OP_POLL, 4'($urandom)));
    send_item(sig_item(CID_SIGNAL, SIG_CFG_RSP, CID_CTRL, 0, 4'($urandom)));
    send_item(sig_item(CID_SIGNAL, SIG_CONN_REQ, PSM_INTR, rc + 16'd2, 4'($urandom)));
    send_item(sig_item(CID_SIGNAL, SIG_CFG_RSP, CID_INTR, 0, 4'($urandom)));
    send_item(sig_item(CID_SDP, 8'($urandom_range(1, 3) * 2), 0, 0, 4'($urandom)));
  endtask

  task automatic outgoing_setup();
    logic [15:0] rc;
    rc = 16'($urandom_range(16'h0040, 16'hFF00));
    cur_h = 12'($urandom);
    send_item(ctl_item(OP_POLL, 4'b0010 | 4'($urandom & 4'b1001)));
    send_item(sig_item(CID_SIGNAL, SIG_CONN_RSP, rc, CID_CTRL, 4'($urandom)));
    send_item(sig_item(CID_SIGNAL, SIG_CFG_RSP, CID_CTRL, 0, 4'($urandom)));
    send_item(sig_item(CID_SIGNAL, SIG_CONN_RSP, rc + 16'd1, CID_INTR, 4'($urandom)));
    send_item(sig_item(CID_SIGNAL, SIG_CFG_RSP, CID_INTR, 0, 4'($urandom)));
    if ($urandom_range(0, 1))
      send_item(sig_item(CID_SIGNAL, SIG_DISC_REQ,
                         16'($urandom_range(0, 1)) + CID_CTRL, 0, 4'($urandom)));
  endtask

  // Writes the protocol mode once every outstanding result has come back.
  task automatic set_mode(logic m);
    push <= 1'b0;
    do @(posedge clk); while (cmd_q.size() != 0);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    protocol_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_mode = m;
  endtask

  task automatic test_no_link();
    item_t it;
    it = noise_item();
    it.op = OP_IDLE;
    send_item(it);
    send_item(ctl_item(OP_POLL, 4'd0));
    it = sig_item(CID_SIGNAL, SIG_INFO_REQ, 16'hFFFF, 16'hFFFF, 4'hF);
    it.acl = 12'hFFF;
    send_item(it);
  endtask

  task automatic test_incoming();
    incoming_setup();
    teardown();
  endtask

  task automatic test_outgoing();
    outgoing_setup();
    send_item(sig_item(CID_SIGNAL, SIG_INFO_REQ, 16'h0002, 0, 4'd0));
    teardown();
  endtask

  task automatic test_random();
    int n;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n > RANDOM_ITEMS - 60) quiet = 1'b1;
      case ($urandom_range(0, 5))
        0: begin incoming_setup(); n += 9; end
        1: begin outgoing_setup(); n += 6; end
        2, 3: begin teardown(); n += 4; end
        default: repeat ($urandom_range(1, 4)) begin
          send_item(noise_item());
          n++;
        end
      endcase
      if (!quiet && $urandom_range(0, 19) == 0) set_mode(1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    p_mode = 0;
    p_link = NO_LINK;
    p_sid = 0;
    p_rcid = '{default: 16'd0};
    drop_link_state();
    cur_h = 12'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_no_link();
    test_incoming();
    set_mode(1'b1);
    test_outgoing();
    set_mode(1'b0);
    test_outgoing();
    set_mode(1'b1);
    test_random();
    push <= 1'b0;
    do @(posedge clk); while (cmd_q.size() != 0);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- l2cap_hid_channel_setup.f -----
hw/rtl/lhcs_pkg.sv
hw/rtl/lhcs_front.sv
hw/rtl/lhcs_fifo.sv
hw/rtl/lhcs_back.sv
hw/rtl/l2cap_hid_channel_setup.sv
sim/tb_l2cap_hid_channel_setup.sv
